@@ hdl/asap_pkg.sv @@
// Shared types and constants for the ANSI SGR attribute parser.
// No dependencies; used by asap_core, the top level and the checker.
package asap_pkg;

  localparam int ATTR_W      = 9;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;
  localparam int QUEUE_DEPTH = 4;
  localparam int M_TDATA_W   = 24;

  localparam logic [BYTE_W-1:0] CH_ESC = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_LBR = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_M   = 8'h6D;

  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 9'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEFAULT_ATTR = 1'b0,
    REG_ATTR_ENABLE  = 1'b1
  } cfg_reg_t;

  // Results caused by one accepted byte: none, one or two text bytes.
  typedef struct packed {
    logic [1:0]        count;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [ATTR_W-1:0] attr;
  } result_t;

  typedef struct packed {
    logic              last;
    logic [ATTR_W-1:0] attr;
    logic [BYTE_W-1:0] data;
  } entry_t;

endpackage

@@ hdl/ansi_sgr_attribute_parser.sv @@
// ANSI SGR attribute parser top level: input stream, parser core, result queue.
// Depends on asap_pkg and asap_core.
//
// Usage:
//   s_* carries one terminal byte per request. m_* carries text bytes, each with
//   the attribute in force; m_tlast marks the last result caused by one input
//   byte. Escape sequences (ESC '[' ... letter) are consumed; with attr_enable
//   set they update the attribute when they end in 'm'. A held ESC not followed
//   by '[' comes out as text, so one input byte causes zero, one or two results.
//   cfg_we/cfg_index/cfg_data write default_attr (index 0) and attr_enable
//   (index 1); write only while the block is idle.
// Timing:
//   One byte per cycle is accepted while s_tready is high. Each result is queued
//   at the edge that accepts its byte, both of a pair together. The parser
//   state updates in the accept cycle, and a queue of QDEPTH result entries sits
//   in front of m_*; s_tready drops while fewer than two entries are free, so a
//   stalled receiver backs up into s_* without loss.
// Reset: rst clears the parser state, empties the queue, sets default_attr to 7
//   and attr_enable to 1; the attribute in force starts at 7.
module ansi_sgr_attribute_parser #(
  parameter int QDEPTH = asap_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // [7:0] in_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [asap_pkg::M_TDATA_W-1:0]      m_tdata,   // [7:0] out_byte, [16:8] out_attr
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [asap_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [asap_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(QDEPTH - 2);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);

  asap_pkg::result_t res;
  asap_pkg::entry_t  queue [QDEPTH];
  asap_pkg::entry_t  head;

  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next, wr_ptr_1;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              accept;
  logic              pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign s_tready = (count <= CNT_ROOM);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;

  asap_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  assign wr_ptr_1 = ptr_inc(wr_ptr);

  always_comb begin
    wr_ptr_next = wr_ptr;
    if (res.count == 2'd1) begin
      wr_ptr_next = wr_ptr_1;
    end else if (res.count == 2'd2) begin
      wr_ptr_next = ptr_inc(wr_ptr_1);
    end
    rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
    count_next  = count + CNT_W'(res.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res.count != 2'd0) begin
      queue[wr_ptr] <= '{last: (res.count == 2'd1), attr: res.attr, data: res.byte0};
    end
    if (res.count == 2'd2) begin
      queue[wr_ptr_1] <= '{last: 1'b1, attr: res.attr, data: res.byte1};
    end
  end

  assign head    = queue[rd_ptr];
  assign m_tdata = {{(asap_pkg::M_TDATA_W - asap_pkg::ATTR_W - asap_pkg::BYTE_W){1'b0}},
                    head.attr, head.data};
  assign m_tlast = head.last;

endmodule

@@ hdl/asap_core.sv @@
// Escape sequence parser: state, SGR code decode and configuration registers.
// Depends on asap_pkg. Produces up to two text results per accepted byte.
module asap_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [asap_pkg::BYTE_W-1:0]        in_byte,
  input  logic                               cfg_we,
  input  logic [asap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [asap_pkg::CFG_DATA_W-1:0]    cfg_data,
  output asap_pkg::result_t                  res
);

  logic                          esc_held, esc_held_next;
  logic                          in_seq, in_seq_next;
  logic [7:0]                    code_acc, code_acc_next;
  logic [asap_pkg::ATTR_W-1:0]   pending_attr, pending_attr_next;
  logic [asap_pkg::ATTR_W-1:0]   current_attr, current_attr_next;
  logic [asap_pkg::ATTR_W-1:0]   default_attr;
  logic                          attr_enable;

  logic                          is_digit;
  logic                          is_letter;
  logic [11:0]                   acc_ext;
  logic [11:0]                   acc_sum;
  logic [asap_pkg::ATTR_W-1:0]   applied;

  // ANSI colour index (bit0 red) to rgb field order (bit2 red)
  function automatic logic [2:0] colour_bits(input logic [2:0] idx);
    colour_bits = {idx[0], idx[1], idx[2]};
  endfunction

  function automatic logic [asap_pkg::ATTR_W-1:0] apply_code(
    input logic [7:0]                  code,
    input logic [asap_pkg::ATTR_W-1:0] attr,
    input logic [asap_pkg::ATTR_W-1:0] dflt
  );
    logic [7:0] fg_idx;
    logic [7:0] bg_idx;
    fg_idx = code - 8'd30;
    bg_idx = code - 8'd40;
    apply_code = attr;
    if (code == 8'd0) begin
      apply_code = dflt;
    end else if (code == 8'd1) begin
      apply_code[3] = 1'b1;
    end else if (code == 8'd4) begin
      apply_code[7] = 1'b1;
    end else if (code == 8'd7) begin
      apply_code[8] = 1'b1;
    end else if (code >= 8'd30 && code <= 8'd37) begin
      apply_code[2:0] = colour_bits(fg_idx[2:0]);
    end else if (code >= 8'd40 && code <= 8'd47) begin
      apply_code[6:4] = colour_bits(bg_idx[2:0]);
    end
  endfunction

  assign is_digit  = (in_byte >= 8'h30) && (in_byte <= 8'h39);
  assign is_letter = ((in_byte >= 8'h41) && (in_byte <= 8'h5A)) ||
                     ((in_byte >= 8'h61) && (in_byte <= 8'h7A));

  // code * 10 + digit, saturating at 255
  assign acc_ext = {4'b0, code_acc};
  assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + {8'b0, in_byte[3:0]};
  assign applied = apply_code(code_acc, pending_attr, default_attr);

  always_comb begin
    esc_held_next     = esc_held;
    in_seq_next       = in_seq;
    code_acc_next     = code_acc;
    pending_attr_next = pending_attr;
    current_attr_next = current_attr;
    res.count         = 2'd0;
    res.byte0         = in_byte;
    res.byte1         = in_byte;
    res.attr          = current_attr;
    if (accept) begin
      if (in_seq) begin
        if (is_digit) begin
          code_acc_next = (acc_sum > 12'd255) ? 8'd255 : acc_sum[7:0];
        end else begin
          pending_attr_next = applied;
          code_acc_next     = 8'd0;
          if (is_letter) begin
            if (in_byte == asap_pkg::CH_M && attr_enable) begin
              current_attr_next = applied;
            end
            in_seq_next = 1'b0;
          end
        end
      end else if (esc_held) begin
        if (in_byte == asap_pkg::CH_LBR) begin
          esc_held_next     = 1'b0;
          in_seq_next       = 1'b1;
          code_acc_next     = 8'd0;
          pending_attr_next = current_attr;
        end else if (in_byte == asap_pkg::CH_ESC) begin
          // emit the held ESC, keep holding the new one
          res.count = 2'd1;
          res.byte0 = asap_pkg::CH_ESC;
        end else begin
          esc_held_next = 1'b0;
          res.count     = 2'd2;
          res.byte0     = asap_pkg::CH_ESC;
        end
      end else if (in_byte == asap_pkg::CH_ESC) begin
        esc_held_next = 1'b1;
      end else begin
        res.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_held     <= 1'b0;
      in_seq       <= 1'b0;
      code_acc     <= 8'd0;
      pending_attr <= '0;
      current_attr <= asap_pkg::DEFAULT_ATTR_RST;
    end else begin
      esc_held     <= esc_held_next;
      in_seq       <= in_seq_next;
      code_acc     <= code_acc_next;
      pending_attr <= pending_attr_next;
      current_attr <= current_attr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= asap_pkg::DEFAULT_ATTR_RST;
      attr_enable  <= 1'b1;
    end else if (cfg_we) begin
      unique case (asap_pkg::cfg_reg_t'(cfg_index))
        asap_pkg::REG_DEFAULT_ATTR: default_attr <= cfg_data[asap_pkg::ATTR_W-1:0];
        asap_pkg::REG_ATTR_ENABLE:  attr_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/asap_checker.sv @@
// Port-level checks for the ANSI SGR attribute parser, bound to the top level.
// Depends on asap_pkg and ansi_sgr_attribute_parser.
module asap_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [asap_pkg::M_TDATA_W-1:0]      m_tdata,
  input logic                                m_tlast
);

  // queue comes out of reset empty, so input is open
  a_ready_after_reset: assert property (@(posedge clk) rst |=> s_tready)
    else $error("s_tready low after reset");

  // only a held ESC is ever followed by a second result of the same byte
  a_first_of_pair_esc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[7:0] == asap_pkg::CH_ESC)
    else $error("non-final result is not ESC");

  // both results of a pair are queued together, so the second follows at once
  a_pair_back_to_back: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
    else $error("second result of a pair missing");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind ansi_sgr_attribute_parser asap_checker u_asap_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast)
);

@@ bench/ansi_sgr_attribute_parser_tb.sv @@
// Self-checking bench for ansi_sgr_attribute_parser: drives byte streams, predicts
// text bytes and attributes in step, and checks every result in order.
// Depends on asap_pkg and the ansi_sgr_attribute_parser RTL.
module ansi_sgr_attribute_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;

  // SGR codes and attribute bits
  localparam int SGR_RESET     = 0;
  localparam int SGR_BOLD      = 1;
  localparam int SGR_UNDERLINE = 4;
  localparam int SGR_REVERSE   = 7;
  localparam int SGR_FG_BASE   = 30;
  localparam int SGR_BG_BASE   = 40;
  localparam logic [asap_pkg::ATTR_W-1:0] BOLD_BIT  = 9'h008;
  localparam logic [asap_pkg::ATTR_W-1:0] UNDER_BIT = 9'h080;
  localparam logic [asap_pkg::ATTR_W-1:0] REV_BIT   = 9'h100;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [7:0]                      s_tdata = 8'h00;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [asap_pkg::M_TDATA_W-1:0]  m_tdata;
  logic                            m_tlast;
  logic                            cfg_we = 1'b0;
  asap_pkg::cfg_reg_t              cfg_index = asap_pkg::REG_DEFAULT_ATTR;
  logic [asap_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Parser state as predicted
  logic [asap_pkg::ATTR_W-1:0] dflt_attr = asap_pkg::DEFAULT_ATTR_RST;
  logic                        sgr_enable = 1'b1;
  logic                        esc_held = 1'b0;
  logic                        in_seq = 1'b0;
  logic [7:0]                  code_acc = 8'd0;
  logic [asap_pkg::ATTR_W-1:0] attr_pending = '0;
  logic [asap_pkg::ATTR_W-1:0] attr_now = asap_pkg::DEFAULT_ATTR_RST;

  asap_pkg::entry_t text_expected[$];
  int     mismatches = 0;
  int     sent = 0;
  int     cycles = 0;
  int     tx_idle_pct = 0;
  int     rx_stall_pct = 0;
  int     hold_req = 0;
  int     hold_seen = 0;
  int     hold_left = 0;

  ansi_sgr_attribute_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] in_byte
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [7:0] out_byte, [16:8] out_attr
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // ANSI colour index is bit0 red; the attribute field is bit2 red
  function automatic logic [2:0] rgb_of(input logic [2:0] idx);
    return {idx[0], idx[1], idx[2]};
  endfunction

  function automatic bit is_letter(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic void apply_sgr(input int code);
    if (code == SGR_RESET) begin
      attr_pending = dflt_attr;
    end else if (code == SGR_BOLD) begin
      attr_pending |= BOLD_BIT;
    end else if (code == SGR_UNDERLINE) begin
      attr_pending |= UNDER_BIT;
    end else if (code == SGR_REVERSE) begin
      attr_pending |= REV_BIT;
    end else if (code >= SGR_FG_BASE && code <= SGR_FG_BASE + 7) begin
      attr_pending[2:0] = rgb_of(3'(code - SGR_FG_BASE));
    end else if (code >= SGR_BG_BASE && code <= SGR_BG_BASE + 7) begin
      attr_pending[6:4] = rgb_of(3'(code - SGR_BG_BASE));
    end
  endfunction

  function automatic void push_text(input logic [7:0] b, input logic lst);
    asap_pkg::entry_t e;
    e.data = b;
    e.attr = attr_now;
    e.last = lst;
    text_expected.insert(text_expected.size(), e);
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    int v;
    if (in_seq) begin
      if (b >= "0" && b <= "9") begin
        v = int'(code_acc) * 10 + int'(b - "0");
        code_acc = (v > 255) ? 8'd255 : 8'(v);
      end else begin
        // any non-digit closes the current code; a letter closes the sequence
        apply_sgr(int'(code_acc));
        code_acc = 8'd0;
        if (is_letter(b)) begin
          if (b == asap_pkg::CH_M && sgr_enable) attr_now = attr_pending;
          in_seq = 1'b0;
        end
      end
    end else if (esc_held) begin
      if (b == asap_pkg::CH_LBR) begin
        esc_held = 1'b0;
        in_seq = 1'b1;
        code_acc = 8'd0;
        attr_pending = attr_now;
      end else if (b == asap_pkg::CH_ESC) begin
        push_text(asap_pkg::CH_ESC, 1'b1);
      end else begin
        esc_held = 1'b0;
        push_text(asap_pkg::CH_ESC, 1'b0);
        push_text(b, 1'b1);
      end
    end else if (b == asap_pkg::CH_ESC) begin
      esc_held = 1'b1;
    end else begin
      push_text(b, 1'b1);
    end
  endfunction

  // Hold valid across back-to-back requests; drop it only for an idle gap
  task automatic send_byte(input logic [7:0] b);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    parse_byte(b);
    sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (text_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input asap_pkg::cfg_reg_t idx,
                           input logic [asap_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == asap_pkg::REG_DEFAULT_ATTR) dflt_attr = val[asap_pkg::ATTR_W-1:0];
    else sgr_enable = val[0];
  endtask

  task automatic send_sgr();
    int nparm;
    int code;
    logic [7:0] sep;
    logic [7:0] fin;
    nparm = $urandom_range(0, 4);
    send_byte(asap_pkg::CH_ESC);
    send_byte(asap_pkg::CH_LBR);
    for (int i = 0; i < nparm; i++) begin
      if (i > 0) begin
        sep = ";";
        if ($urandom_range(9) == 0) begin
          do sep = 8'($urandom_range(255));
          while ((sep >= "0" && sep <= "9") || is_letter(sep));
        end
        send_byte(sep);
      end
      case ($urandom_range(9))
        0: code = SGR_RESET;
        1: code = ($urandom_range(2) == 0) ? SGR_BOLD :
                  ($urandom_range(1) == 0) ? SGR_UNDERLINE : SGR_REVERSE;
        2, 3: code = SGR_FG_BASE + $urandom_range(7);
        4, 5: code = SGR_BG_BASE + $urandom_range(7);
        6: code = $urandom_range(99);
        7: code = $urandom_range(256, 99999);
        8: code = -1;   // empty code
        default: code = $urandom_range(100, 255);
      endcase
      if (code >= 0) send_str($sformatf("%0d", code));
    end
    fin = asap_pkg::CH_M;
    if ($urandom_range(3) == 0) begin
      fin = ($urandom_range(1) == 0) ? 8'("A" + $urandom_range(25)) :
                                       8'("a" + $urandom_range(25));
    end
    send_byte(fin);
  endtask

  // Mostly well-formed sequences and text, with stray escapes and raw noise
  task automatic send_mixed(input int n);
    int target;
    int pick;
    target = sent + n;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_sgr();
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
      end else if (pick < 92) begin
        send_byte(asap_pkg::CH_ESC);
        if ($urandom_range(1) == 0) send_byte(asap_pkg::CH_ESC);
        send_byte(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_text_and_sgr();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(asap_pkg::CH_ESC);
    send_byte(asap_pkg::CH_ESC);
    send_byte("Z");
    send_byte(asap_pkg::CH_ESC);
    send_byte(asap_pkg::CH_LBR);
    send_str("1;4;7;31;46");
    send_byte(asap_pkg::CH_M);
    send_byte("a");
    send_byte(asap_pkg::CH_ESC);
    send_byte(asap_pkg::CH_LBR);
    send_byte(asap_pkg::CH_M);
    send_byte("b");
  endtask

  task automatic test_sequence_edges();
    // saturated code, then a final letter that is not 'm'
    send_byte(asap_pkg::CH_ESC);
    send_byte(asap_pkg::CH_LBR);
    send_str("300;1H");
    send_byte("c");
  endtask

  task automatic test_streaming_no_idle();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_mixed(350);
  endtask

  task automatic test_default_extremes();
    wait_idle();
    write_reg(asap_pkg::REG_DEFAULT_ATTR, 9'h000);
    tx_idle_pct = 75;
    rx_stall_pct = 0;
    send_mixed(250);
    wait_idle();
    write_reg(asap_pkg::REG_DEFAULT_ATTR, 9'h1FF);
    tx_idle_pct = 0;
    rx_stall_pct = 75;
    send_mixed(300);
  endtask

  task automatic test_attr_disabled();
    wait_idle();
    write_reg(asap_pkg::REG_ATTR_ENABLE, 9'd0);
    write_reg(asap_pkg::REG_DEFAULT_ATTR, 9'($urandom_range(511)));
    tx_idle_pct = 17;
    rx_stall_pct = 17;
    send_mixed(250);
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_reg(asap_pkg::REG_ATTR_ENABLE, 9'd1);
    write_reg(asap_pkg::REG_DEFAULT_ATTR, 9'($urandom_range(511)));
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req <= hold_req + 1;
    send_mixed(150);
    tx_idle_pct = 17;
    rx_stall_pct = 17;
    send_mixed(150);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    asap_pkg::entry_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (text_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: byte %02h attr %03h last %0b",
                   m_tdata[7:0], m_tdata[16:8], m_tlast);
      end else begin
        e = text_expected.pop_front();
        if (m_tdata[7:0] !== e.data || m_tdata[16:8] !== e.attr || m_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected byte %02h attr %03h last %0b, got byte %02h attr %03h last %0b",
                     e.data, e.attr, e.last, m_tdata[7:0], m_tdata[16:8], m_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_text_and_sgr();
    test_sequence_edges();
    test_streaming_no_idle();
    test_default_extremes();
    test_attr_disabled();
    test_backpressure();
    wait_idle();
    if (text_expected.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/asap_pkg.sv
hdl/asap_core.sv
hdl/ansi_sgr_attribute_parser.sv
hdl/asap_checker.sv
bench/ansi_sgr_attribute_parser_tb.sv
